>>> design/mid_pkg.sv
// Shared constants, types and register codes for the integrate-and-dump decimator.
package mid_pkg;

  localparam int MAX_CHANNELS = 1024;
  localparam int MAX_FACTOR   = 1024;
  localparam int SAMPLE_BITS  = 16;

  localparam int POWER_BITS   = 16;
  localparam int SUM_BITS     = 26;
  localparam int CH_BITS      = 10;
  localparam int TC_BITS      = 10;
  localparam int REG_BITS     = 11;
  localparam int CFG_IDX_BITS = 4;

  localparam logic [SUM_BITS-1:0] SUM_MAX    = '1;
  localparam logic [REG_BITS-1:0] FACTOR_MIN = REG_BITS'(2);
  localparam logic [REG_BITS-1:0] FACTOR_LIM = REG_BITS'(MAX_FACTOR);
  localparam logic [REG_BITS-1:0] NCHAN_MIN  = REG_BITS'(1);
  localparam logic [REG_BITS-1:0] NCHAN_LIM  = REG_BITS'(MAX_CHANNELS);
  localparam logic [REG_BITS-1:0] DECIM_RST  = REG_BITS'(2);
  localparam logic [REG_BITS-1:0] NCHAN_RST  = REG_BITS'(1);

  typedef logic [CH_BITS-1:0]  chan_t;
  typedef logic [TC_BITS-1:0]  tcount_t;
  typedef logic [REG_BITS-1:0] reg_t;
  typedef logic [SUM_BITS-1:0] sum_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DECIM = CFG_IDX_BITS'(0),
    REG_NCHAN = CFG_IDX_BITS'(1)
  } cfg_reg_t;

  // Per-request control handed from the sequencer to the accumulate stage.
  typedef struct packed {
    chan_t chan;
    logic  first;
    logic  emit;
    logic  last;
  } item_ctl_t;

endpackage

>>> design/mid_in_if.sv
// Input sample channel: valid/ready with one power sample.
interface mid_in_if;
  logic                             valid;
  logic                             ready;
  logic [mid_pkg::POWER_BITS-1:0]   power;

  modport source (output valid, output power, input ready);
  modport sink   (input valid, input power, output ready);
endinterface

>>> design/mid_out_if.sv
// Result channel: valid/ready with one channel sum.
interface mid_out_if;
  logic                           valid;
  logic                           ready;
  logic [mid_pkg::SUM_BITS-1:0]   sum;
  logic [mid_pkg::CH_BITS-1:0]    channel;
  logic                           last_of_frame;

  modport source (output valid, output sum, output channel, output last_of_frame, input ready);
  modport sink   (input valid, input sum, input channel, input last_of_frame, output ready);
endinterface

>>> design/mid_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
interface mid_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mid_pkg::CFG_IDX_BITS-1:0]   index;
  logic [mid_pkg::REG_BITS-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/mid_seq.sv
// Configuration registers and channel/time position counters.
module mid_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [mid_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mid_pkg::REG_BITS-1:0]      cfg_data,
  input  logic                              in_accept,
  output mid_pkg::item_ctl_t                item_ctl
);

  mid_pkg::reg_t    decim_r, decim_nxt;
  mid_pkg::reg_t    nchan_r, nchan_nxt;
  mid_pkg::chan_t   chan_cnt_r, chan_cnt_nxt;
  mid_pkg::tcount_t time_cnt_r, time_cnt_nxt;

  mid_pkg::reg_t    eff_f;
  mid_pkg::reg_t    eff_n;
  mid_pkg::chan_t   chan_cur;
  mid_pkg::reg_t    chan_inc;
  mid_pkg::reg_t    time_inc;

  // Clamp register values to the supported range.
  always_comb begin
    eff_f = decim_r;
    if (decim_r < mid_pkg::FACTOR_MIN) eff_f = mid_pkg::FACTOR_MIN;
    if (decim_r > mid_pkg::FACTOR_LIM) eff_f = mid_pkg::FACTOR_LIM;
    eff_n = nchan_r;
    if (nchan_r < mid_pkg::NCHAN_MIN) eff_n = mid_pkg::NCHAN_MIN;
    if (nchan_r > mid_pkg::NCHAN_LIM) eff_n = mid_pkg::NCHAN_LIM;
  end

  always_comb begin
    chan_cur = (mid_pkg::REG_BITS'(chan_cnt_r) >= eff_n) ? '0 : chan_cnt_r;
    chan_inc = mid_pkg::REG_BITS'(chan_cur) + mid_pkg::REG_BITS'(1);
    time_inc = mid_pkg::REG_BITS'(time_cnt_r) + mid_pkg::REG_BITS'(1);

    item_ctl.chan  = chan_cur;
    item_ctl.first = (time_cnt_r == '0);
    item_ctl.emit  = (time_inc >= eff_f);
    item_ctl.last  = (chan_inc == eff_n);
  end

  always_comb begin
    decim_nxt    = decim_r;
    nchan_nxt    = nchan_r;
    chan_cnt_nxt = chan_cnt_r;
    time_cnt_nxt = time_cnt_r;
    if (cfg_valid) begin
      case (cfg_index)
        mid_pkg::REG_DECIM: begin
          decim_nxt    = cfg_data;
          chan_cnt_nxt = '0;
          time_cnt_nxt = '0;
        end
        mid_pkg::REG_NCHAN: begin
          nchan_nxt    = cfg_data;
          chan_cnt_nxt = '0;
          time_cnt_nxt = '0;
        end
        default: ;
      endcase
    end else if (in_accept) begin
      // Advance channel; wrap into the next time step of the group.
      if (chan_inc >= eff_n) begin
        chan_cnt_nxt = '0;
        time_cnt_nxt = (time_inc >= eff_f) ? '0 : time_inc[mid_pkg::TC_BITS-1:0];
      end else begin
        chan_cnt_nxt = chan_inc[mid_pkg::CH_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decim_r    <= mid_pkg::DECIM_RST;
      nchan_r    <= mid_pkg::NCHAN_RST;
      chan_cnt_r <= '0;
      time_cnt_r <= '0;
    end else begin
      decim_r    <= decim_nxt;
      nchan_r    <= nchan_nxt;
      chan_cnt_r <= chan_cnt_nxt;
      time_cnt_r <= time_cnt_nxt;
    end
  end

endmodule

>>> design/mid_accum.sv
// Accumulator memory, accumulate stage with write forwarding, and result register.
module mid_accum (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mid_pkg::POWER_BITS-1:0]   in_power,
  input  mid_pkg::item_ctl_t               in_ctl,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mid_pkg::sum_t                    out_sum,
  output mid_pkg::chan_t                   out_channel,
  output logic                             out_last
);

  mid_pkg::sum_t acc_mem [mid_pkg::MAX_CHANNELS];

  logic                              s1_v_r;
  mid_pkg::item_ctl_t                s1_ctl_r;
  logic [mid_pkg::SAMPLE_BITS-1:0]   s1_pow_r;
  mid_pkg::sum_t                     rd_r;
  logic                              fwd_r;
  mid_pkg::sum_t                     fwd_acc_r;

  logic                              out_v_r;
  mid_pkg::sum_t                     out_sum_r;
  mid_pkg::chan_t                    out_chan_r;
  logic                              out_last_r;

  logic                              accept;
  logic                              out_free;
  logic                              s1_adv;
  mid_pkg::sum_t                     base;
  logic [mid_pkg::SUM_BITS:0]        sum_wide;
  mid_pkg::sum_t                     acc;

  assign out_free = !out_v_r || out_ready;
  assign s1_adv   = s1_v_r && (!s1_ctl_r.emit || out_free);
  assign in_ready = !s1_v_r || s1_adv;
  assign accept   = in_valid && in_ready;

  // Take the value just written when the previous request hit the same channel.
  always_comb begin
    base     = fwd_r ? fwd_acc_r : rd_r;
    sum_wide = {1'b0, base} + (mid_pkg::SUM_BITS+1)'(s1_pow_r);
    if (s1_ctl_r.first) begin
      acc = mid_pkg::SUM_BITS'(s1_pow_r);
    end else if (sum_wide[mid_pkg::SUM_BITS]) begin
      acc = mid_pkg::SUM_MAX;
    end else begin
      acc = sum_wide[mid_pkg::SUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r     <= acc_mem[in_ctl.chan];
      s1_ctl_r <= in_ctl;
      s1_pow_r <= in_power[mid_pkg::SAMPLE_BITS-1:0];
      fwd_r    <= s1_adv && (s1_ctl_r.chan == in_ctl.chan);
    end
    if (s1_adv) begin
      acc_mem[s1_ctl_r.chan] <= acc;
      fwd_acc_r              <= acc;
    end
    if (s1_adv && s1_ctl_r.emit) begin
      out_sum_r  <= acc;
      out_chan_r <= s1_ctl_r.chan;
      out_last_r <= s1_ctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv && s1_ctl_r.emit) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_v_r;
  assign out_sum     = out_sum_r;
  assign out_channel = out_chan_r;
  assign out_last    = out_last_r;

endmodule

>>> design/multichannel_integrate_and_dump.sv
// Top level of the multichannel integrate-and-dump decimator.
// Power samples arrive time-major, all num_channels values of a time step in a row.
// Each channel owns an accumulator in a 1024 x 26-bit memory (one read, one write
// port); the first step of a group of decim_factor steps overwrites it, later steps
// add to it with saturation at 26 bits, and on the last step of the group each
// channel's sum leaves with its channel number and a flag on the final channel.
// The block takes one sample per clock while ready is high. An accepted request reads
// the memory into the accumulate stage, which then adds, writes back and loads the
// result register. Consecutive requests to the same channel (num_channels of 1) are
// covered by forwarding the value written in the same cycle. While a result waits, samples
// that produce no result keep flowing; ready drops once the next result-bearing sample
// reaches the accumulate stage. Any write to a known register restarts the group at
// channel 0; accumulator contents are kept but are always overwritten before being read.
// The memory is not cleared after reset. Configuration writes are taken at any time but
// are meant for idle periods.
module multichannel_integrate_and_dump (
  input  logic      clk,
  input  logic      rst_n,
  mid_in_if.sink    in_ch,
  mid_out_if.source out_ch,
  mid_cfg_if.sink   cfg_ch
);

  mid_pkg::item_ctl_t item_ctl;
  logic               in_accept;
  logic               in_ready;

  // Configuration writes never stall.
  assign cfg_ch.ready = 1'b1;

  assign in_ch.ready = in_ready;
  assign in_accept   = in_ch.valid && in_ready;

  // Track channel and time position; decode register writes.
  mid_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .in_accept (in_accept),
    .item_ctl  (item_ctl)
  );

  // Read, add, write back and hold the result for the sink.
  mid_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ready),
    .in_power    (in_ch.power),
    .in_ctl      (item_ctl),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_sum     (out_ch.sum),
    .out_channel (out_ch.channel),
    .out_last    (out_ch.last_of_frame)
  );

endmodule

>>> design/mid_checker.sv
// Port-level checks for the decimator, bound to the top level.
module mid_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mid_pkg::SUM_BITS-1:0] out_sum,
  input logic [mid_pkg::CH_BITS-1:0]  out_channel,
  input logic                         out_last
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sum) && $stable(out_channel) && $stable(out_last))
    else $error("stalled result changed");

  // An empty result register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // A fresh result comes from an accepted request that passed through the accumulate stage.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching request");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind multichannel_integrate_and_dump mid_checker u_mid_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_sum     (out_ch.sum),
  .out_channel (out_ch.channel),
  .out_last    (out_ch.last_of_frame)
);

>>> tb/tb_multichannel_integrate_and_dump.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multichannel integrate-and-dump decimator.
module tb_multichannel_integrate_and_dump;

  localparam int STALL_LIMIT = 2000;  // cycles with no handshake on any channel
  localparam int SETTLE_CYCLES = 8;   // lets samples with no result leave the pipeline
  localparam int BUSY_PCT = 36;

  // One channel sum as it should leave the block.
  typedef struct {
    mid_pkg::sum_t  sum;
    mid_pkg::chan_t chan;
    logic           last;
  } dump_t;

  logic clk;
  logic rst_n;

  mid_in_if  in_ch();
  mid_out_if out_ch();
  mid_cfg_if cfg_ch();

  multichannel_integrate_and_dump DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Power samples waiting to be offered, and sums still owed by the block.
  logic [mid_pkg::POWER_BITS-1:0] power_q[$];
  dump_t                          sums_due[$];

  // Mirror of the block: register values, accumulators and position in the group.
  mid_pkg::reg_t fac_reg;
  mid_pkg::reg_t nch_reg;
  mid_pkg::sum_t acc_mem [mid_pkg::MAX_CHANNELS];
  int unsigned   chan_pos;
  int unsigned   step_pos;

  int  in_idle_pct;
  int  out_idle_pct;
  int  hold_left;
  bit  in_taken;
  int  idle_cycles;
  int  errors;
  int  n_samples;
  int  n_dumps;
  int  n_writes;
  int  n_frames;

  always #2 clk = ~clk;

  // Accumulate one accepted sample and queue the sum it dumps, if any.
  function automatic void integrate_sample(logic [mid_pkg::POWER_BITS-1:0] p);
    int unsigned     f;
    int unsigned     n;
    int unsigned     c;
    longint unsigned total;
    dump_t           d;
    f = fac_reg;
    if (f < mid_pkg::FACTOR_MIN) f = mid_pkg::FACTOR_MIN;
    if (f > mid_pkg::FACTOR_LIM) f = mid_pkg::FACTOR_LIM;
    n = nch_reg;
    if (n < mid_pkg::NCHAN_MIN) n = mid_pkg::NCHAN_MIN;
    if (n > mid_pkg::NCHAN_LIM) n = mid_pkg::NCHAN_LIM;
    c = chan_pos;
    if (c >= n) c = 0;
    // First step of a group overwrites, later steps add.
    total = longint'(p) % (longint'(1) << mid_pkg::SAMPLE_BITS);
    if (step_pos != 0) total += longint'(acc_mem[c]);
    if (total > mid_pkg::SUM_MAX) total = mid_pkg::SUM_MAX;
    acc_mem[c] = mid_pkg::sum_t'(total);
    if (step_pos + 1 >= f) begin
      d.sum  = mid_pkg::sum_t'(total);
      d.chan = mid_pkg::chan_t'(c);
      d.last = (c + 1 == n);
      sums_due.push_back(d);
    end
    c++;
    if (c >= n) begin
      c = 0;
      step_pos++;
      if (step_pos >= f) step_pos = 0;
    end
    chan_pos = c;
  endfunction

  // Mostly random power, with the rails well represented.
  function automatic logic [mid_pkg::POWER_BITS-1:0] pick_power();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return mid_pkg::POWER_BITS'($urandom);
    endcase
  endfunction

  // Input driver: change the request at the falling edge, drop or advance it once taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (power_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.power <= power_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready: hold off for a counted stretch on request, otherwise stall at random.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Monitor: sample all handshakes at the rising edge, predict, check and watch for hangs.
  always @(posedge clk) begin
    in_taken = in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        n_writes++;
        // A write to a known register restarts the group; other indexes are ignored.
        case (cfg_ch.index)
          mid_pkg::REG_DECIM: begin
            fac_reg  = cfg_ch.data;
            chan_pos = 0;
            step_pos = 0;
          end
          mid_pkg::REG_NCHAN: begin
            nch_reg  = cfg_ch.data;
            chan_pos = 0;
            step_pos = 0;
          end
          default: ;
        endcase
      end
      if (in_taken) begin
        n_samples++;
        integrate_sample(in_ch.power);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (sums_due.size() == 0) begin
          $error("unexpected result: sum %0d channel %0d last_of_frame %0b",
                 out_ch.sum, out_ch.channel, out_ch.last_of_frame);
          errors++;
        end else begin
          dump_t d;
          d = sums_due.pop_front();
          n_dumps++;
          if (out_ch.last_of_frame) n_frames++;
          if (out_ch.sum !== d.sum) begin
            $error("sum: expected %0d, got %0d", d.sum, out_ch.sum);
            errors++;
          end
          if (out_ch.channel !== d.chan) begin
            $error("channel: expected %0d, got %0d", d.chan, out_ch.channel);
            errors++;
          end
          if (out_ch.last_of_frame !== d.last) begin
            $error("last_of_frame: expected %0b, got %0b", d.last, out_ch.last_of_frame);
            errors++;
          end
        end
      end
      if (in_taken || (out_ch.valid && out_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("tb_multichannel_integrate_and_dump: FAIL");
        $finish;
      end
    end
  end

  // Wait until every queued sample is taken and every owed sum has come, then let
  // the pipeline empty out, since a partial group leaves samples with no result.
  task automatic settle();
    while (power_q.size() != 0 || in_ch.valid || sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [mid_pkg::CFG_IDX_BITS-1:0] idx, mid_pkg::reg_t val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Set both registers while idle, in random order.
  task automatic program_regs(mid_pkg::reg_t fac, mid_pkg::reg_t nch);
    settle();
    if ($urandom_range(1)) begin
      write_reg(mid_pkg::REG_DECIM, fac);
      write_reg(mid_pkg::REG_NCHAN, nch);
    end else begin
      write_reg(mid_pkg::REG_NCHAN, nch);
      write_reg(mid_pkg::REG_DECIM, fac);
    end
  endtask

  initial begin
    int          f;
    int          nc;
    int          grp;
    int          cnt;
    int          rand_items;
    int          phase;
    logic [mid_pkg::CFG_IDX_BITS-1:0] bad_idx;

    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.power  = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    in_idle_pct  = BUSY_PCT;
    out_idle_pct = BUSY_PCT;
    hold_left    = 0;
    in_taken     = 1'b0;
    idle_cycles  = 0;
    errors       = 0;
    n_samples    = 0;
    n_dumps      = 0;
    n_writes     = 0;
    n_frames     = 0;
    fac_reg      = mid_pkg::DECIM_RST;
    nch_reg      = mid_pkg::NCHAN_RST;
    chan_pos     = 0;
    step_pos     = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: factor 2, one channel. Hit the rails and alternating bits,
    // and leave one sample of a group held.
    power_q = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h1234};
    settle();

    // Factor 0 reads as 2. Leave one sample of the next group pending.
    program_regs(mid_pkg::reg_t'(0), mid_pkg::reg_t'(2));
    power_q = '{16'h8001, 16'h7FFE, 16'hFFFF, 16'h0001, 16'hC3C3};
    settle();

    // Unknown index: nothing changes, so the pending group completes.
    bad_idx = mid_pkg::CFG_IDX_BITS'($urandom_range(2 ** mid_pkg::CFG_IDX_BITS - 1,
                                                    int'(mid_pkg::REG_NCHAN) + 1));
    write_reg(bad_idx, mid_pkg::reg_t'($urandom));
    power_q = '{16'h3C3C, 16'hFFFF, 16'h0F0F};

    // Rewriting an unchanged value still restarts the group.
    power_q.push_back(16'h0002);
    settle();
    write_reg(mid_pkg::REG_NCHAN, mid_pkg::reg_t'(2));
    power_q = '{16'h00FF, 16'hFF00, 16'hFFFF, 16'hFFFF};
    settle();

    // Out-of-range settings clamp: factor 1 and all-ones channels, then the reverse.
    program_regs(mid_pkg::reg_t'(1), '1);
    power_q = '{pick_power(), pick_power()};
    program_regs('1, mid_pkg::reg_t'(0));
    power_q = '{pick_power(), pick_power()};

    // Fill the block: withhold ready for a long stretch while samples keep coming.
    program_regs(mid_pkg::reg_t'(2), mid_pkg::reg_t'(1));
    in_idle_pct = 0;
    hold_left   = 300;
    repeat (200) power_q.push_back(pick_power());
    settle();
    in_idle_pct = BUSY_PCT;
    rand_items  = 200;

    // Random settings, mostly small so that sums come often; each phase may end on a
    // partial group that the next write drops.
    phase = 0;
    while (rand_items < 1850 - mid_pkg::MAX_FACTOR || phase < 5) begin
      if ($urandom_range(4) == 0) begin
        f  = $urandom_range(40, 9);
        nc = $urandom_range(8, 1);
      end else begin
        f  = $urandom_range(6, 2);
        nc = ($urandom_range(4) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
      end
      grp = f * nc;
      cnt = grp * ((grp > 100) ? 1 : $urandom_range(5, 2)) + $urandom_range(grp - 1, 0);
      program_regs(mid_pkg::reg_t'(f), mid_pkg::reg_t'(nc));
      if (phase == 2) begin
        // No idling on either side for a whole phase, long enough to matter.
        cnt += grp * (200 / grp + 1);
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if (phase == 4) begin
        // Pause the sender mid-phase until every owed sum has come.
        repeat (cnt / 2) power_q.push_back(pick_power());
        settle();
        repeat (cnt - cnt / 2) power_q.push_back(pick_power());
      end else begin
        repeat (cnt) power_q.push_back(pick_power());
      end
      settle();
      in_idle_pct  = BUSY_PCT;
      out_idle_pct = BUSY_PCT;
      rand_items += cnt;
      phase++;
    end

    // Largest factor at full scale gives the largest possible sum.
    program_regs(mid_pkg::reg_t'(mid_pkg::MAX_FACTOR), mid_pkg::reg_t'(1));
    repeat (mid_pkg::MAX_FACTOR) power_q.push_back('1);
    settle();

    if (sums_due.size() != 0) begin
      $error("%0d expected sums never arrived", sums_due.size());
      errors++;
    end
    $display("covered %0d samples, %0d sums (%0d frame ends), %0d register writes",
             n_samples, n_dumps, n_frames, n_writes);
    $display("factors from 2 to %0d, up to 64 channels, and clamped out-of-range settings",
             mid_pkg::MAX_FACTOR);
    if (errors == 0) begin
      $display("tb_multichannel_integrate_and_dump: PASS");
    end else begin
      $display("tb_multichannel_integrate_and_dump: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
design/mid_pkg.sv
design/mid_in_if.sv
design/mid_out_if.sv
design/mid_cfg_if.sv
design/mid_seq.sv
design/mid_accum.sv
design/multichannel_integrate_and_dump.sv
design/mid_checker.sv
tb/tb_multichannel_integrate_and_dump.sv
